// ===== sv/edr_pkg.sv =====
package edr_pkg;

    localparam int CFG_DW  = 16;
    localparam int CFG_IW  = 3;
    localparam int DELAY_W = 12;

    localparam logic [27:0] DELAY_MUL = 28'd3821;

    localparam logic [CFG_IW-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IW-1:0] REG_LOW_THR   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_HIGH_THR  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_START_CNT = 3'd3;
    localparam logic [CFG_IW-1:0] REG_END_CNT   = 3'd4;
    localparam logic [CFG_IW-1:0] REG_DIST_CM   = 3'd5;
    localparam logic [CFG_IW-1:0] REG_PULSE_MS  = 3'd6;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_ON     = 2'd1;
    localparam logic [1:0] MODE_DETECT = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] low_threshold;
        logic [11:0] high_threshold;
        logic [7:0]  start_count;
        logic [7:0]  end_count;
        logic [15:0] dist_cm;
        logic [7:0]  pulse_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mode:           MODE_OFF,
        low_threshold:  12'd1800,
        high_threshold: 12'd2300,
        start_count:    8'd3,
        end_count:      8'd3,
        dist_cm:        16'd30,
        pulse_ms:       8'd1
    };

    typedef struct packed {
        logic        drive_on;
        logic        in_pulse;
        logic [31:0] period_ms;
        logic        period_new;
    } result_t;

endpackage

// ===== sv/edr_core.sv =====
module edr_core #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  edr_pkg::cfg_t          cfg,
    input  logic                   clr,
    input  logic                   step,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   sample_ok,
    input  logic [31:0]            now_ms,
    output edr_pkg::result_t       res
);
    import edr_pkg::*;

    localparam int CMPW = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
    localparam int RUNW = (COUNT_BITS > 8) ? COUNT_BITS : 8;

    logic [DELAY_W-1:0]    delay_ms;
    logic [27:0]           delay_prod;

    logic                  inside_reg, inside_next;
    logic [COUNT_BITS-1:0] out_run_reg, out_run_next;
    logic [COUNT_BITS-1:0] in_run_reg, in_run_next;
    logic [31:0]           last_start_reg, last_start_next;
    logic [31:0]           period_reg, period_next;
    logic                  waiting_reg, waiting_next;
    logic [31:0]           wait_start_reg, wait_start_next;
    logic                  burst_reg, burst_next;
    logic [31:0]           burst_start_reg, burst_start_next;

    logic [SAMPLE_BITS-1:0] smp;
    logic                   in_window;
    logic [COUNT_BITS-1:0]  out_inc, in_inc;
    logic                   fresh;
    logic                   wait_now;
    logic [31:0]            wait_start_cur;

    assign delay_prod = 28'(cfg.dist_cm) * DELAY_MUL;
    assign delay_ms   = delay_prod[27:16];

    assign smp       = sample_ok ? sample : '0;
    assign in_window = (CMPW'(smp) >= CMPW'(cfg.low_threshold)) &&
                       (CMPW'(smp) <= CMPW'(cfg.high_threshold));
    assign out_inc   = (out_run_reg == '1) ? out_run_reg : out_run_reg + 1'b1;
    assign in_inc    = (in_run_reg == '1) ? in_run_reg : in_run_reg + 1'b1;

    always_comb begin
        inside_next      = inside_reg;
        out_run_next     = out_run_reg;
        in_run_next      = in_run_reg;
        last_start_next  = last_start_reg;
        period_next      = period_reg;
        waiting_next     = waiting_reg;
        wait_start_next  = wait_start_reg;
        burst_next       = burst_reg;
        burst_start_next = burst_start_reg;
        fresh            = 1'b0;
        wait_now         = waiting_reg;
        wait_start_cur   = wait_start_reg;

        if (cfg.mode == MODE_DETECT) begin
            if (!inside_reg) begin
                if (!in_window) begin
                    out_run_next = out_inc;
                    if (RUNW'(out_inc) >= RUNW'(cfg.start_count)) begin
                        if (last_start_reg != '0) begin
                            period_next = now_ms - last_start_reg;
                            fresh       = 1'b1;
                        end
                        last_start_next = now_ms;
                        out_run_next    = '0;
                        inside_next     = 1'b1;
                    end
                end else begin
                    out_run_next = '0;
                end
            end else begin
                if (in_window) begin
                    in_run_next = in_inc;
                    if (RUNW'(in_inc) >= RUNW'(cfg.end_count)) begin
                        inside_next    = 1'b0;
                        in_run_next    = '0;
                        wait_now       = 1'b1;
                        wait_start_cur = now_ms;
                    end
                end else begin
                    in_run_next = '0;
                end
            end

            waiting_next    = wait_now;
            wait_start_next = wait_start_cur;
            // burst that starts this step ends at once only for a zero length
            if (wait_now && ((now_ms - wait_start_cur) >= 32'(delay_ms))) begin
                waiting_next     = 1'b0;
                burst_start_next = now_ms;
                burst_next       = (cfg.pulse_ms != '0);
            end else if (burst_reg &&
                         ((now_ms - burst_start_reg) >= 32'(cfg.pulse_ms))) begin
                burst_next = 1'b0;
            end
        end

        res.drive_on   = (cfg.mode == MODE_ON) ||
                         ((cfg.mode == MODE_DETECT) && burst_next);
        res.in_pulse   = inside_next;
        res.period_ms  = period_next;
        res.period_new = fresh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg      <= 1'b0;
            out_run_reg     <= '0;
            in_run_reg      <= '0;
            last_start_reg  <= '0;
            period_reg      <= '0;
            waiting_reg     <= 1'b0;
            wait_start_reg  <= '0;
            burst_reg       <= 1'b0;
            burst_start_reg <= '0;
        end else if (clr) begin
            inside_reg     <= 1'b0;
            out_run_reg    <= '0;
            in_run_reg     <= '0;
            last_start_reg <= '0;
            waiting_reg    <= 1'b0;
            burst_reg      <= 1'b0;
        end else if (step) begin
            inside_reg      <= inside_next;
            out_run_reg     <= out_run_next;
            in_run_reg      <= in_run_next;
            last_start_reg  <= last_start_next;
            period_reg      <= period_next;
            waiting_reg     <= waiting_next;
            wait_start_reg  <= wait_start_next;
            burst_reg       <= burst_next;
            burst_start_reg <= burst_start_next;
        end
    end

endmodule

// ===== sv/echo_detect_delayed_retransmit.sv =====
// Pipeline: two register stages; an accepted input word is held in the input
// register and its result word is registered in the output register as it moves on.
// Throughput: one word per cycle while m_tready does not stall the output; input and output registers with shared
// stall, detector state is updated in a single pass in the compute stage.
// Reset (aresetn low, synchronous): pipeline empty, detector and timers
// cleared, registers back to mode 0, window 1800..2300, counts 3, 30 cm, 1 ms.
module echo_detect_delayed_retransmit #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 8
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [edr_pkg::CFG_IW-1:0]              cfg_idx,
    input  logic [edr_pkg::CFG_DW-1:0]              cfg_data,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // sample, now_ms
    input  logic [((SAMPLE_BITS+32+7)/8)*8-1:0]     s_tdata,
    // sample_ok
    input  logic                                    s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // drive_on, in_pulse, period_ms[31:0], period_new
    output logic [39:0]                             m_tdata
);
    import edr_pkg::*;

    cfg_t                   cfg_reg;
    logic                   in_vld_reg;
    logic [SAMPLE_BITS-1:0] in_smp_reg;
    logic                   in_ok_reg;
    logic [31:0]            in_now_reg;
    logic                   out_vld_reg;
    result_t                out_reg;
    result_t                res;
    logic                   adv;
    logic                   step;
    logic                   clr;

    assign adv      = !out_vld_reg || m_tready;
    assign step     = in_vld_reg && adv;
    assign s_tready = !in_vld_reg || adv;
    assign clr      = cfg_we && (cfg_idx == REG_MODE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_MODE:      cfg_reg.mode           <= cfg_data[1:0];
                REG_LOW_THR:   cfg_reg.low_threshold  <= cfg_data[11:0];
                REG_HIGH_THR:  cfg_reg.high_threshold <= cfg_data[11:0];
                REG_START_CNT: cfg_reg.start_count    <= cfg_data[7:0];
                REG_END_CNT:   cfg_reg.end_count      <= cfg_data[7:0];
                REG_DIST_CM:   cfg_reg.dist_cm        <= cfg_data[15:0];
                REG_PULSE_MS:  cfg_reg.pulse_ms       <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_smp_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_now_reg <= s_tdata[SAMPLE_BITS +: 32];
            in_ok_reg  <= s_tuser;
        end
    end

    edr_core #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .clr      (clr),
        .step     (step),
        .sample   (in_smp_reg),
        .sample_ok(in_ok_reg),
        .now_ms   (in_now_reg),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b0, out_reg.period_new, out_reg.period_ms,
                       out_reg.in_pulse, out_reg.drive_on};

    a_word_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_tvalid)
        else $error("stage word not moved to output");

    a_period_in_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[34]) |-> m_tdata[1])
        else $error("period update without pulse start");

    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && out_vld_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline stalled");

endmodule

// ===== tb/echo_detect_delayed_retransmit_tb.sv =====
`timescale 1ns / 1ps

module echo_detect_delayed_retransmit_tb;
    import edr_pkg::*;

    localparam logic [1:0]        MODE_UNUSED = 2'd3;
    localparam logic [CFG_IW-1:0] REG_NONE    = 3'd7;
    localparam int PIPE_LAT          = 2;
    localparam int STALL_LIMIT       = 2000;
    localparam int IDLE_PASSES       = 3;
    localparam int SETTINGS_PER_PASS = 5;
    localparam int WORDS_PER_SETTING = 84;

    localparam result_t R_IDLE  = '{drive_on: 1'b0, in_pulse: 1'b0, period_ms: 32'd0,
                                    period_new: 1'b0};
    localparam result_t R_DRIVE = '{drive_on: 1'b1, in_pulse: 1'b0, period_ms: 32'd0,
                                    period_new: 1'b0};

    typedef struct packed {
        logic              is_reg;
        logic [CFG_IW-1:0] idx;
        logic [CFG_DW-1:0] val;
        logic [11:0]       smp;
        logic              ok;
        logic [31:0]       now;
        logic              typed;
        result_t           want;
    } step_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_idx;
    logic [CFG_DW-1:0] cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [47:0]       s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [39:0]       m_tdata;

    echo_detect_delayed_retransmit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow registers and detector state
    cfg_t        shadow = CFG_RESET;
    logic        inside_p = 1'b0;
    logic [7:0]  out_run = 8'd0;
    logic [7:0]  in_run = 8'd0;
    logic [31:0] last_start = 32'd0;
    logic [31:0] period_v = 32'd0;
    logic        waiting_f = 1'b0;
    logic [31:0] wait_t0 = 32'd0;
    logic        bursting_f = 1'b0;
    logic [31:0] burst_t0 = 32'd0;

    result_t     result_q[$];
    step_t       dir_tab[$];
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    logic [31:0] clock_ms = 32'd0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    int          n_settings = 0;
    int          stall_cycles = 0;
    result_t     got;
    result_t     want;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic result_t echo_predict(logic [11:0] smp_in, logic ok, logic [31:0] now);
        logic [11:0] smp;
        logic        in_win;
        logic [31:0] dly;
        result_t     r;
        smp = ok ? smp_in : 12'd0;
        r = '0;
        case (shadow.mode)
            MODE_ON: begin
                r.drive_on = 1'b1;
            end
            MODE_DETECT: begin
                in_win = (smp >= shadow.low_threshold) && (smp <= shadow.high_threshold);
                dly = ({16'd0, shadow.dist_cm} * {4'd0, DELAY_MUL}) >> 16;
                if (!inside_p) begin
                    if (!in_win) begin
                        if (out_run != 8'hFF) out_run = out_run + 8'd1;
                        if (out_run >= shadow.start_count) begin
                            if (last_start != 32'd0) begin
                                period_v = now - last_start;
                                r.period_new = 1'b1;
                            end
                            last_start = now;
                            out_run = 8'd0;
                            inside_p = 1'b1;
                        end
                    end else begin
                        out_run = 8'd0;
                    end
                end else begin
                    if (in_win) begin
                        if (in_run != 8'hFF) in_run = in_run + 8'd1;
                        if (in_run >= shadow.end_count) begin
                            inside_p = 1'b0;
                            in_run = 8'd0;
                            waiting_f = 1'b1;
                            wait_t0 = now;
                        end
                    end else begin
                        in_run = 8'd0;
                    end
                end
                if (waiting_f && (now - wait_t0) >= dly) begin
                    bursting_f = 1'b1;
                    burst_t0 = now;
                    waiting_f = 1'b0;
                end
                if (bursting_f && (now - burst_t0) >= {24'd0, shadow.pulse_ms})
                    bursting_f = 1'b0;
                r.drive_on = bursting_f;
            end
            default: begin
            end
        endcase
        r.in_pulse = inside_p;
        r.period_ms = period_v;
        return r;
    endfunction

    function automatic step_t reg_row(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        step_t s;
        s = '0;
        s.is_reg = 1'b1;
        s.idx = idx;
        s.val = val;
        return s;
    endfunction

    function automatic step_t word_row(logic [11:0] smp, logic ok, logic [31:0] now,
                                       logic typed, result_t want_r);
        step_t s;
        s = '0;
        s.smp = smp;
        s.ok = ok;
        s.now = now;
        s.typed = typed;
        s.want = want_r;
        return s;
    endfunction

    function automatic logic [11:0] out_sample();
        int          lo;
        int          hi;
        int unsigned v;
        lo = shadow.low_threshold;
        hi = shadow.high_threshold;
        v = $urandom_range(0, 4095);
        if (lo <= hi) begin
            if (lo > 0 && (hi == 4095 || $urandom_range(0, 1) == 0))
                v = $urandom_range(0, lo - 1);
            else if (hi < 4095)
                v = $urandom_range(hi + 1, 4095);
        end
        return v[11:0];
    endfunction

    function automatic logic [11:0] in_sample();
        int          lo;
        int          hi;
        int unsigned v;
        lo = shadow.low_threshold;
        hi = shadow.high_threshold;
        v = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 4095);
        return v[11:0];
    endfunction

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(negedge aclk);
        repeat (PIPE_LAT + 2) @(negedge aclk);
    endtask

    task automatic reg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE: begin
                shadow.mode = val[1:0];
                inside_p = 1'b0;
                out_run = 8'd0;
                in_run = 8'd0;
                last_start = 32'd0;
                waiting_f = 1'b0;
                bursting_f = 1'b0;
            end
            REG_LOW_THR:   shadow.low_threshold = val[11:0];
            REG_HIGH_THR:  shadow.high_threshold = val[11:0];
            REG_START_CNT: shadow.start_count = val[7:0];
            REG_END_CNT:   shadow.end_count = val[7:0];
            REG_DIST_CM:   shadow.dist_cm = val;
            REG_PULSE_MS:  shadow.pulse_ms = val[7:0];
            default: begin
            end
        endcase
    endtask

    task automatic send_word(logic [11:0] smp, logic ok, logic [31:0] now,
                             logic typed, result_t want_r);
        result_t r;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, now, smp};
        s_tuser <= ok;
        do @(posedge aclk); while (s_tready !== 1'b1);
        r = echo_predict(smp, ok, now);
        result_q.push_back(typed ? want_r : r);
        n_sent++;
    endtask

    task automatic new_setting(int ph);
        int unsigned lo;
        int unsigned hi;
        int unsigned sc;
        int unsigned ec;
        int unsigned dcm;
        int unsigned pms;
        int unsigned sel;
        logic [1:0]  md;
        if (ph == 4) begin
            lo = 0;
            hi = 4095;
            sc = 255;
            ec = 255;
            dcm = 65535;
            pms = 255;
            md = MODE_DETECT;
        end else begin
            sel = $urandom_range(0, 9);
            lo = (sel == 0) ? 0 : (sel == 1) ? 4095 : $urandom_range(0, 2500);
            sel = $urandom_range(0, 9);
            if (sel == 0) hi = 4095;
            else if (sel == 1) hi = $urandom_range(0, 4095);
            else hi = (lo + $urandom_range(0, 1500) > 4095) ? 4095 : lo + $urandom_range(0, 1500);
            sel = $urandom_range(0, 9);
            sc = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(1, 4);
            sel = $urandom_range(0, 9);
            ec = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(1, 4);
            sel = $urandom_range(0, 9);
            dcm = (sel == 0) ? 0 : (sel == 1) ? 65535 : $urandom_range(0, 120);
            sel = $urandom_range(0, 9);
            pms = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(1, 8);
            sel = $urandom_range(0, 9);
            md = (sel == 0) ? MODE_OFF : (sel == 1) ? MODE_ON :
                 (sel == 2) ? MODE_UNUSED : MODE_DETECT;
        end
        reg_write(REG_LOW_THR, lo[15:0]);
        reg_write(REG_HIGH_THR, hi[15:0]);
        reg_write(REG_START_CNT, sc[15:0]);
        reg_write(REG_END_CNT, ec[15:0]);
        reg_write(REG_DIST_CM, dcm[15:0]);
        reg_write(REG_PULSE_MS, pms[15:0]);
        if ($urandom_range(0, 3) == 0) reg_write(REG_NONE, 16'hFFFF);
        reg_write(REG_MODE, {14'd0, md});
        sel = $urandom_range(0, 3);
        if (sel == 0) clock_ms = $urandom;
        else if (sel == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 150);
        else if (sel == 2) clock_ms = 32'd0;
        n_settings++;
    endtask

    task automatic rand_word(logic quiet);
        int unsigned v;
        logic        ok;
        logic [11:0] smp;
        clock_ms = clock_ms + $urandom_range(0, 2);
        ok = 1'b1;
        if ($urandom_range(0, 99) < 12) begin
            v = $urandom;
            smp = v[11:0];
            ok = v[12];
            if (v[15:13] == 3'd0) clock_ms = $urandom;
        end else if (quiet) begin
            smp = in_sample();
        end else begin
            smp = out_sample();
            if ($urandom_range(0, 5) == 0 && shadow.low_threshold != 12'd0) ok = 1'b0;
        end
        send_word(smp, ok, clock_ms, 1'b0, R_IDLE);
    endtask

    // pulse-shaped sequences: out-of-window run, in-window run, quiet gap
    task automatic pulse_train(int count);
        int k;
        int n_out;
        int n_in;
        int gap;
        int sc;
        int ec;
        sc = (shadow.start_count == 8'd0) ? 1 : shadow.start_count;
        ec = (shadow.end_count == 8'd0) ? 1 : shadow.end_count;
        k = 0;
        while (k < count) begin
            n_out = ($urandom_range(0, 3) == 0) ? $urandom_range(1, sc) : sc;
            n_in = ($urandom_range(0, 3) == 0) ? $urandom_range(1, ec) : ec;
            gap = $urandom_range(0, 12);
            for (int i = 0; i < n_out + n_in + gap && k < count; i++) begin
                rand_word(i >= n_out);
                k++;
            end
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.drive_on = m_tdata[0];
            got.in_pulse = m_tdata[1];
            got.period_ms = m_tdata[33:2];
            got.period_new = m_tdata[34];
            n_checked++;
            if (result_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: result word %0d with nothing expected", n_checked);
            end else begin
                want = result_q.pop_front();
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("ERROR: word %0d exp drive %0b pulse %0b period %0d new %0b",
                                 n_checked, want.drive_on, want.in_pulse, want.period_ms,
                                 want.period_new);
                        $display("       got drive %0b pulse %0b period %0d new %0b",
                                 got.drive_on, got.in_pulse, got.period_ms, got.period_new);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        send_idle = 36;
        recv_idle = 76;

        // off after reset
        dir_tab.push_back(word_row(12'd4095, 1'b1, 32'd0, 1'b1, R_IDLE));
        dir_tab.push_back(word_row(12'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, R_IDLE));
        dir_tab.push_back(word_row(12'd2000, 1'b1, 32'h5555_5555, 1'b1, R_IDLE));
        // continuous drive
        dir_tab.push_back(reg_row(REG_MODE, {14'd0, MODE_ON}));
        dir_tab.push_back(word_row(12'd4095, 1'b1, 32'hAAAA_AAAA, 1'b1, R_DRIVE));
        dir_tab.push_back(word_row(12'd0, 1'b0, 32'd0, 1'b1, R_DRIVE));
        // unused mode acts as off
        dir_tab.push_back(reg_row(REG_MODE, {14'd0, MODE_UNUSED}));
        dir_tab.push_back(word_row(12'd4095, 1'b1, 32'd1, 1'b1, R_IDLE));
        dir_tab.push_back(reg_row(REG_NONE, 16'hFFFF));
        // detect with reset settings: first start at time zero
        dir_tab.push_back(reg_row(REG_MODE, {14'd0, MODE_DETECT}));
        dir_tab.push_back(word_row(12'd4095, 1'b1, 32'd0, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd0, 1'b1, 32'd0, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd2301, 1'b1, 32'd0, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd1800, 1'b1, 32'd1, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd2300, 1'b1, 32'd2, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd2000, 1'b1, 32'd3, 1'b0, R_IDLE));
        // invalid sample counts as zero, burst starts
        dir_tab.push_back(word_row(12'd2000, 1'b0, 32'd4, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd1799, 1'b1, 32'd5, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd4095, 1'b1, 32'd6, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd2000, 1'b1, 32'd7, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd2000, 1'b1, 32'd8, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd2000, 1'b1, 32'd9, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd100, 1'b1, 32'd10, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd3000, 1'b1, 32'd10, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd4000, 1'b1, 32'd11, 1'b0, R_IDLE));
        // zero counts, zero delay and zero burst
        dir_tab.push_back(reg_row(REG_START_CNT, 16'd0));
        dir_tab.push_back(reg_row(REG_END_CNT, 16'd0));
        dir_tab.push_back(reg_row(REG_DIST_CM, 16'd0));
        dir_tab.push_back(reg_row(REG_PULSE_MS, 16'd0));
        dir_tab.push_back(word_row(12'd4095, 1'b1, 32'd20, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd2000, 1'b1, 32'd21, 1'b0, R_IDLE));
        // inverted window
        dir_tab.push_back(reg_row(REG_LOW_THR, 16'd4095));
        dir_tab.push_back(reg_row(REG_HIGH_THR, 16'd0));
        dir_tab.push_back(word_row(12'd2000, 1'b1, 32'd22, 1'b0, R_IDLE));
        dir_tab.push_back(word_row(12'd4095, 1'b1, 32'd23, 1'b0, R_IDLE));

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_reg) begin
                settle();
                reg_write(dir_tab[i].idx, dir_tab[i].val);
            end else begin
                send_word(dir_tab[i].smp, dir_tab[i].ok, dir_tab[i].now,
                          dir_tab[i].typed, dir_tab[i].want);
            end
        end

        for (int pass = 0; pass < IDLE_PASSES; pass++) begin
            send_idle = (pass == 0) ? 36 : (pass == 1) ? 76 : 0;
            recv_idle = (pass == 0) ? 76 : (pass == 1) ? 36 : 0;
            for (int s = 0; s < SETTINGS_PER_PASS; s++) begin
                settle();
                new_setting(pass * SETTINGS_PER_PASS + s);
                pulse_train(WORDS_PER_SETTING);
            end
        end
        settle();

        $display("Sent %0d sample words over %0d random register settings plus directed cases",
                 n_sent, n_settings);
        $display("Checked %0d result words, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0 && result_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== echo_detect_delayed_retransmit.f =====
sv/edr_pkg.sv
sv/edr_core.sv
sv/echo_detect_delayed_retransmit.sv
tb/echo_detect_delayed_retransmit_tb.sv
